/* hw/rtl/hpa_pkg.sv */
// Shared types and constants of the handle pool allocator.
`default_nettype none

package hpa_pkg;

    localparam int HANDLE_W   = 6;
    localparam int WORD_W     = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_SEL_LO = 2;
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_NEW,
        OP_FREE,
        OP_READ,
        OP_RSVD
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EXHAUSTED,
        ST_INVALID,
        ST_IN_USE,
        ST_STACK_FULL
    } status_t;

    typedef enum logic {
        REG_DEFAULT_FRICTION,
        REG_DEFAULT_RESTITUTION
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] default_friction;
        logic [WORD_W-1:0] default_restitution;
    } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/hpa_ram.sv */
// Simple dual-port memory with registered read data and write-to-read bypass.
`default_nettype none

module hpa_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/hpa_cfg.sv */
// Register port holding the default property words.
`default_nettype none

module hpa_cfg import hpa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_reg_t sel;

    assign sel    = cfg_reg_t'(paddr[REG_SEL_LO]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (sel)
                REG_DEFAULT_FRICTION: begin
                    cfg_reg.default_friction <= pwdata;
                end
                REG_DEFAULT_RESTITUTION: begin
                    cfg_reg.default_restitution <= pwdata;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_DEFAULT_FRICTION:    prdata = cfg_reg.default_friction;
            REG_DEFAULT_RESTITUTION: prdata = cfg_reg.default_restitution;
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hw/rtl/hpa_core.sv */
// Input stage, handle bookkeeping and result register of the allocator.
`default_nettype none

module hpa_core import hpa_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [HANDLE_W-1:0] s_handle,
    input  wire logic                s_use_default,
    input  wire logic [WORD_W-1:0]   s_friction_in,
    input  wire logic [WORD_W-1:0]   s_restitution_in,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [HANDLE_W-1:0]      m_handle_out,
    output logic [WORD_W-1:0]        m_friction_out,
    output logic [WORD_W-1:0]        m_restitution_out
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int PROP_W = 2 * WORD_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic [HANDLE_W-1:0] s1_handle_reg;
    logic                s1_dflt_reg;
    logic [WORD_W-1:0]   s1_fric_reg;
    logic [WORD_W-1:0]   s1_rest_reg;

    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    next_fresh_reg, next_fresh_next;

    logic                res_valid_reg;
    status_t             res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [WORD_W-1:0]   res_fric_reg, res_fric_next;
    logic [WORD_W-1:0]   res_rest_reg, res_rest_next;

    logic                s1_adv;
    logic                s_accept;
    logic                h_known;
    logic [IDX_W-1:0]    h_idx;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    in_idx;

    logic [PROP_W-1:0]   prop_rd;
    logic                prop_we;
    logic [0:0]          used_rd;
    logic                used_we;
    logic [IDX_W-1:0]    used_waddr;
    logic [0:0]          used_wdata;
    logic [IDX_W-1:0]    stack_rd;
    logic                stack_we;
    logic [CNT_W-1:0]    fc_eff;
    logic [CNT_W-1:0]    fc_top;

    assign s1_adv   = s1_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    assign h_known = CMP_W'(s1_handle_reg) < CMP_W'(next_fresh_reg);
    assign h_idx   = IDX_W'(s1_handle_reg);
    assign in_idx  = IDX_W'(s_handle);

    // The stack top for the next word follows the count this word leaves.
    assign fc_eff = s1_adv ? free_count_next : free_count_reg;
    assign fc_top = fc_eff - ONE_CNT;

    always_comb begin
        res_status_next = ST_OK;
        res_handle_next = '0;
        res_fric_next   = '0;
        res_rest_next   = '0;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        slot            = stack_rd;
        prop_we         = 1'b0;
        used_we         = 1'b0;
        used_waddr      = h_idx;
        used_wdata      = 1'b0;
        stack_we        = 1'b0;
        case (s1_op_reg)
            OP_NEW: begin
                // The slot taken from the stack or the fresh indexes is marked in use.
                if (free_count_reg != '0) begin
                    slot            = stack_rd;
                    free_count_next = free_count_reg - ONE_CNT;
                end else if (next_fresh_reg == CAP_CNT) begin
                    res_status_next = ST_EXHAUSTED;
                end else begin
                    slot            = next_fresh_reg[IDX_W-1:0];
                    next_fresh_next = next_fresh_reg + ONE_CNT;
                end
                if (res_status_next == ST_OK) begin
                    prop_we         = 1'b1;
                    used_we         = 1'b1;
                    used_waddr      = slot;
                    used_wdata      = 1'b1;
                    res_handle_next = HANDLE_W'(slot);
                end
            end
            OP_FREE: begin
                if (!h_known) begin
                    res_status_next = ST_INVALID;
                end else if (used_rd[0]) begin
                    if (free_count_reg == CAP_CNT) begin
                        res_status_next = ST_STACK_FULL;
                    end else begin
                        used_we         = 1'b1;
                        stack_we        = 1'b1;
                        free_count_next = free_count_reg + ONE_CNT;
                    end
                end
            end
            OP_READ: begin
                if (s1_dflt_reg) begin
                    res_fric_next = cfg.default_friction;
                    res_rest_next = cfg.default_restitution;
                end else if (!h_known) begin
                    res_status_next = ST_INVALID;
                end else begin
                    res_fric_next = prop_rd[WORD_W-1:0];
                    res_rest_next = prop_rd[PROP_W-1:WORD_W];
                end
            end
            default: begin
                res_status_next = ST_INVALID;
            end
        endcase
    end

    hpa_ram #(.DEPTH(CAPACITY), .DATA_W(PROP_W)) u_prop_ram (
        .aclk    (aclk),
        .wr_en   (prop_we && s1_adv),
        .wr_addr (slot),
        .wr_data ({s1_rest_reg, s1_fric_reg}),
        .rd_en   (s_accept),
        .rd_addr (in_idx),
        .rd_data (prop_rd)
    );

    hpa_ram #(.DEPTH(CAPACITY), .DATA_W(1)) u_used_ram (
        .aclk    (aclk),
        .wr_en   (used_we && s1_adv),
        .wr_addr (used_waddr),
        .wr_data (used_wdata),
        .rd_en   (s_accept),
        .rd_addr (in_idx),
        .rd_data (used_rd)
    );

    hpa_ram #(.DEPTH(CAPACITY), .DATA_W(IDX_W)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stack_we && s1_adv),
        .wr_addr (free_count_reg[IDX_W-1:0]),
        .wr_data (h_idx),
        .rd_en   (s_accept),
        .rd_addr (fc_top[IDX_W-1:0]),
        .rd_data (stack_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            free_count_reg <= '0;
            next_fresh_reg <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                res_valid_reg  <= 1'b1;
                free_count_reg <= free_count_next;
                next_fresh_reg <= next_fresh_next;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_op_reg     <= op_t'(s_operation);
            s1_handle_reg <= s_handle;
            s1_dflt_reg   <= s_use_default;
            s1_fric_reg   <= s_friction_in;
            s1_rest_reg   <= s_restitution_in;
        end
        if (s1_adv) begin
            res_status_reg <= res_status_next;
            res_handle_reg <= res_handle_next;
            res_fric_reg   <= res_fric_next;
            res_rest_reg   <= res_rest_next;
        end
    end

    assign m_tvalid          = res_valid_reg;
    assign m_status          = res_status_reg;
    assign m_handle_out      = res_handle_reg;
    assign m_friction_out    = res_fric_reg;
    assign m_restitution_out = res_rest_reg;

endmodule

`default_nettype wire

/* hw/rtl/handle_pool_allocator_top.sv */
// Top level of the handle pool allocator.
//
// The slave stream takes one request word per cycle while it is not stalled:
// new (store two property words in a fresh or recycled handle), free (return
// a handle), or read (fetch the words of a handle, or the default words). The
// master stream returns one result word per request, in order, carrying a
// status code in m_tuser. The default words are set through the register port
// at byte addresses 0 and 4; the user must set them only while the stream is
// idle, as the block itself does not enforce this. A request accepted by the
// slave stream is registered together with its memory reads in the input
// stage, and its result is then loaded into the output register once that
// register is free or being taken. One request is taken every cycle while the
// receiver does not stall; the property, in-use and free-stack memories have
// registered read ports. Reset empties the pool and the free stack and clears
// the default words; no clearing pass runs, so requests are taken as soon as
// reset is released. When the receiver stalls, the result waits in the output
// register, one more request waits in the input stage, and s_tready then
// falls until a result is taken.
`default_nettype none

module handle_pool_allocator_top import hpa_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: handle, friction_in, restitution_in, zero fill.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: operation, use_default.
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: handle_out, friction_out, restitution_out, zero fill.
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: status.
    output logic      [M_TUSER_W-1:0]  m_tuser
);

    localparam int FRIC_LO = HANDLE_W;
    localparam int REST_LO = HANDLE_W + WORD_W;
    localparam int PAD_LO  = HANDLE_W + 2 * WORD_W;

    cfg_t                cfg;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_handle_out;
    logic [WORD_W-1:0]   m_friction_out;
    logic [WORD_W-1:0]   m_restitution_out;

    hpa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpa_core #(.CAPACITY(CAPACITY)) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_operation       (s_tuser[OP_W-1:0]),
        .s_handle          (s_tdata[HANDLE_W-1:0]),
        .s_use_default     (s_tuser[OP_W]),
        .s_friction_in     (s_tdata[REST_LO-1:FRIC_LO]),
        .s_restitution_in  (s_tdata[PAD_LO-1:REST_LO]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_status          (m_status),
        .m_handle_out      (m_handle_out),
        .m_friction_out    (m_friction_out),
        .m_restitution_out (m_restitution_out)
    );

    assign m_tdata = {(M_TDATA_W - PAD_LO)'(0), m_restitution_out, m_friction_out,
                      m_handle_out};
    assign m_tuser = m_status;

    // A ready receiver never holds up the request side.
    a_no_stall_when_drained: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready
    ) else $error("s_tready low while m_tready high");

    // A failed request carries no handle and no property words.
    a_error_word_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0)
    ) else $error("error result carries nonzero data");

    // An accepted request passes the input stage and the result register to the output if not stalled.
    a_latency: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready |=> m_tvalid
    ) else $error("result missing two cycles after acceptance");

endmodule

`default_nettype wire
